// ===== design/znlt_pkg.sv =====
// ============================================================================
// znlt_pkg: shared constants and types of the zoned node location table
// Table geometry, mode/status/tag codes and mixer constants.
// ============================================================================
package znlt_pkg;

    // geometry (both sizes must be powers of two)
    localparam int ZONE_SLOTS    = 16;
    localparam int TRACKER_SLOTS = 64;
    localparam int ZIDX_W        = $clog2(ZONE_SLOTS);
    localparam int EIDX_W        = $clog2(TRACKER_SLOTS);
    localparam int ADDR_W        = ZIDX_W + EIDX_W;
    localparam int DEPTH         = ZONE_SLOTS * TRACKER_SLOTS;

    // entry tags
    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    // request modes
    localparam logic [2:0] MODE_LOOKUP   = 3'd0;
    localparam logic [2:0] MODE_UPDATE   = 3'd1;
    localparam logic [2:0] MODE_MIGRATE  = 3'd2;
    localparam logic [2:0] MODE_REMOVE   = 3'd3;
    localparam logic [2:0] MODE_SEAL_SET = 3'd4;
    localparam logic [2:0] MODE_SEAL_GET = 3'd5;
    localparam logic [2:0] MODE_LIST     = 3'd6;

    // result status
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INVALID   = 3'd2;
    localparam logic [2:0] ST_ZONE_FULL = 3'd3;
    localparam logic [2:0] ST_NODE_FULL = 3'd4;

    // configuration register indexes
    localparam int          CFG_IDX_W     = 1;
    localparam logic [0:0]  CFG_INV_ZONE  = 1'd0;
    localparam logic [0:0]  CFG_INV_NODE  = 1'd1;

    // splitmix64 finalizer
    localparam logic [63:0] MIX_C1    = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2    = 64'h94d049bb133111eb;
    localparam logic [31:0] ZONE_SALT = 32'h9e3779b9;

    typedef struct packed {
        logic [1:0]  tag;
        logic [31:0] node;
        logic [31:0] slot;
    } entry_t;

endpackage

// ===== design/zoned_node_location_table_unit.sv =====
// ============================================================================
// zoned_node_location_table_unit: two-level node location table
// Zone directory in flops, node entries in one synchronous RAM, linear probing.
// ============================================================================
//
//  channel | ports            | direction | carries
//  --------+------------------+-----------+--------------------------------
//  request | s_valid/s_ready  | in        | mode, zone, node, slot, prev, seal
//  result  | m_valid/m_ready  | out       | status, zone, node, slot, seal, last
//  config  | cfg_valid/ready  | in        | cfg_index, cfg_data
//
//  Flow: one request at a time. Each key is hashed in turn on the shared
//  mixer (one to three keys per request), a zone probe takes one bucket per
//  cycle and an entry probe reads, then checks, each slot (RAM read latency).
//  List walks the whole zone row, reading and checking each entry in turn.
//  Reset: a clearing pass writes every entry tag empty, all DEPTH (1024)
//  entries, with s_ready low; configuration writes are taken throughout.
//  Stalls: the result register frees the core; it only waits when a second
//  result is due while the first has not been taken.
//
module zoned_node_location_table_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_mode,
    input  logic [31:0]                    s_zone_id,
    input  logic [31:0]                    s_node_id,
    input  logic [31:0]                    s_slot_id,
    input  logic [31:0]                    s_prev_zone_id,
    input  logic                           s_seal_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status,
    output logic [31:0]                    m_found_zone,
    output logic [31:0]                    m_found_node,
    output logic [31:0]                    m_found_slot,
    output logic                           m_sealed,
    output logic                           m_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [znlt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import znlt_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIN    = 4'd1;
    localparam logic [3:0] S_HSEL   = 4'd2;
    localparam logic [3:0] S_HWAIT  = 4'd3;
    localparam logic [3:0] S_BEGIN  = 4'd4;
    localparam logic [3:0] S_ZW     = 4'd5;
    localparam logic [3:0] S_ZDONE  = 4'd6;
    localparam logic [3:0] S_EWRD   = 4'd7;
    localparam logic [3:0] S_EWCK   = 4'd8;
    localparam logic [3:0] S_EDONE  = 4'd9;
    localparam logic [3:0] S_SCAN   = 4'd10;
    localparam logic [3:0] S_MIGCHK = 4'd11;
    localparam logic [3:0] S_FINRES = 4'd12;
    localparam logic [3:0] S_LRD    = 4'd13;
    localparam logic [3:0] S_LCK    = 4'd14;
    localparam logic [3:0] S_LEND   = 4'd15;

    // request phase
    localparam logic [1:0] PH_MAIN = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_PREV = 2'd2;

    // zone walk outcome
    localparam logic [1:0] ZW_HIT  = 2'd0;
    localparam logic [1:0] ZW_FREE = 2'd1;
    localparam logic [1:0] ZW_FULL = 2'd2;

    // hash in flight
    localparam logic [1:0] HS_Z = 2'd0;
    localparam logic [1:0] HS_N = 2'd1;
    localparam logic [1:0] HS_P = 2'd2;

    localparam logic [ZIDX_W-1:0] ZLAST = ZIDX_W'(ZONE_SLOTS - 1);
    localparam logic [EIDX_W-1:0] ELAST = EIDX_W'(TRACKER_SLOTS - 1);

    logic [3:0]  state_reg;
    logic [31:0] inv_zone_reg;
    logic [31:0] inv_node_reg;

    // latched request
    logic [2:0]  mode_reg;
    logic [31:0] z_reg;
    logic [31:0] n_reg;
    logic [31:0] s_reg;
    logic [31:0] pz_reg;
    logic        sv_reg;
    logic        hinted_reg;
    logic        need_z_reg;
    logic        need_n_reg;
    logic        need_p_reg;
    logic [1:0]  hsel_reg;
    logic [1:0]  phase_reg;

    // hashed start positions
    logic [ZIDX_W-1:0] zpos_reg;
    logic [ZIDX_W-1:0] ppos_reg;
    logic [EIDX_W-1:0] npos_reg;

    // zone directory
    logic [ZONE_SLOTS-1:0] zone_valid_reg;
    logic [ZONE_SLOTS-1:0] zone_seal_reg;
    logic [31:0]           zone_key_reg [ZONE_SLOTS];

    // walk state; zcur is the one directory index used everywhere
    logic [ZIDX_W-1:0] zcur_reg;
    logic [ZIDX_W-1:0] zw_cnt_reg;
    logic [31:0]       zw_key_reg;
    logic [1:0]        zw_res_reg;
    logic [EIDX_W-1:0] epos_reg;
    logic [EIDX_W-1:0] ew_cnt_reg;
    logic              ew_pub_reg;
    logic              ew_hit_reg;
    logic [31:0]       ew_slot_reg;

    // pending result
    logic [2:0]  res_status_reg;
    logic [31:0] res_zone_reg;
    logic [31:0] res_node_reg;
    logic [31:0] res_slot_reg;
    logic        res_seal_reg;

    // list lookahead, so the final entry can carry last
    logic        pend_v_reg;
    logic [31:0] pend_node_reg;
    logic [31:0] pend_slot_reg;

    // output register
    logic        m_valid_reg;
    logic [2:0]  m_status_reg;
    logic [31:0] m_zone_reg;
    logic [31:0] m_node_reg;
    logic [31:0] m_slot_reg;
    logic        m_seal_reg;
    logic        m_last_reg;
    logic        m_load;

    // clearing pass
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // entry RAM
    entry_t            emem [DEPTH];
    entry_t            rdata_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;

    // mixer
    logic        hash_start;
    logic [63:0] hash_in;
    logic        hash_done;
    logic [63:0] hash_h;

    logic        accept;
    logic        out_free;
    logic        ew_match;
    logic        ew_claim;
    logic        tomb_on_hit;
    logic        cur_valid;
    logic        cur_seal;
    logic [31:0] cur_key;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == S_IDLE) && !clr_active_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // a result enters the output register: list hit behind a pending one,
    // last list hit, or the single result of a request
    assign m_load = out_free && (
                        ((state_reg == S_LCK) && (rdata_reg.tag == TAG_LIVE) && pend_v_reg)
                     || ((state_reg == S_LEND) && pend_v_reg)
                     || (state_reg == S_FIN));

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found_zone = m_zone_reg;
    assign m_found_node = m_node_reg;
    assign m_found_slot = m_slot_reg;
    assign m_sealed     = m_seal_reg;
    assign m_last       = m_last_reg;

    assign cur_valid = zone_valid_reg[zcur_reg];
    assign cur_seal  = zone_seal_reg[zcur_reg];
    assign cur_key   = zone_key_reg[zcur_reg];

    assign mem_addr    = {zcur_reg, epos_reg};
    assign ew_match    = (rdata_reg.tag == TAG_LIVE) && (rdata_reg.node == n_reg);
    assign ew_claim    = (rdata_reg.tag != TAG_LIVE) || (rdata_reg.node == n_reg);
    assign tomb_on_hit = (mode_reg == MODE_REMOVE) || (phase_reg == PH_PREV);
    assign mem_re      = (state_reg == S_EWRD) || (state_reg == S_LRD);

    // RAM write: clearing pass, claim on publish, tombstone on find hit
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = mem_addr;
        mem_wdata = '{tag: TAG_TOMB, node: rdata_reg.node, slot: rdata_reg.slot};
        if (clr_active_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '{tag: TAG_EMPTY, node: 32'd0, slot: 32'd0};
        end else if (state_reg == S_EWCK) begin
            if (ew_pub_reg && ew_claim) begin
                mem_we    = 1'b1;
                mem_wdata = '{tag: TAG_LIVE, node: n_reg, slot: s_reg};
            end else if (!ew_pub_reg && ew_match && tomb_on_hit) begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) emem[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= emem[mem_addr];
    end

    // hash requests in priority order: zone, node, previous zone
    always_comb begin
        hash_start = (state_reg == S_HSEL) && (need_z_reg || need_n_reg || need_p_reg);
        if (need_z_reg)      hash_in = {32'd0, z_reg ^ ZONE_SALT};
        else if (need_n_reg) hash_in = {32'd0, n_reg};
        else                 hash_in = {32'd0, pz_reg ^ ZONE_SALT};
    end

    znlt_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (hash_start),
        .x_in    (hash_in),
        .done    (hash_done),
        .h       (hash_h)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inv_zone_reg <= 32'hFFFF_FFFF;
            inv_node_reg <= 32'd0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_INV_ZONE: inv_zone_reg <= cfg_data;
                CFG_INV_NODE: inv_node_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // output valid: load wins over a take in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (m_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            zone_valid_reg <= '0;
            zone_seal_reg  <= '0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            pend_v_reg     <= 1'b0;
            need_z_reg     <= 1'b0;
            need_n_reg     <= 1'b0;
            need_p_reg     <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) clr_active_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        logic zbad;
                        logic nbad;
                        logic bad;
                        zbad = (s_zone_id == inv_zone_reg);
                        nbad = (s_node_id == inv_node_reg);
                        case (s_mode)
                            MODE_LOOKUP: bad = nbad;
                            MODE_UPDATE, MODE_MIGRATE, MODE_REMOVE: bad = nbad || zbad;
                            MODE_SEAL_SET, MODE_SEAL_GET, MODE_LIST: bad = zbad;
                            default: bad = 1'b1;
                        endcase
                        mode_reg       <= s_mode;
                        z_reg          <= s_zone_id;
                        n_reg          <= s_node_id;
                        s_reg          <= s_slot_id;
                        pz_reg         <= s_prev_zone_id;
                        sv_reg         <= s_seal_value;
                        hinted_reg     <= !zbad;
                        res_status_reg <= bad ? ST_INVALID : ST_OK;
                        res_zone_reg   <= 32'd0;
                        res_node_reg   <= 32'd0;
                        res_slot_reg   <= 32'd0;
                        res_seal_reg   <= 1'b0;
                        need_z_reg     <= !zbad;
                        need_n_reg     <= (s_mode == MODE_LOOKUP) || (s_mode == MODE_UPDATE)
                                       || (s_mode == MODE_MIGRATE) || (s_mode == MODE_REMOVE);
                        need_p_reg     <= (s_mode == MODE_MIGRATE)
                                       && (s_prev_zone_id != inv_zone_reg)
                                       && (s_prev_zone_id != s_zone_id);
                        state_reg      <= bad ? S_FIN : S_HSEL;
                    end
                end

                S_HSEL: begin
                    if (need_z_reg) begin
                        need_z_reg <= 1'b0;
                        hsel_reg   <= HS_Z;
                        state_reg  <= S_HWAIT;
                    end else if (need_n_reg) begin
                        need_n_reg <= 1'b0;
                        hsel_reg   <= HS_N;
                        state_reg  <= S_HWAIT;
                    end else if (need_p_reg) begin
                        need_p_reg <= 1'b0;
                        hsel_reg   <= HS_P;
                        state_reg  <= S_HWAIT;
                    end else begin
                        state_reg <= S_BEGIN;
                    end
                end

                S_HWAIT: begin
                    if (hash_done) begin
                        case (hsel_reg)
                            HS_Z:    zpos_reg <= hash_h[ZIDX_W-1:0];
                            HS_N:    npos_reg <= hash_h[EIDX_W-1:0];
                            default: ppos_reg <= hash_h[ZIDX_W-1:0];
                        endcase
                        state_reg <= S_HSEL;
                    end
                end

                S_BEGIN: begin
                    if (mode_reg == MODE_LOOKUP && !hinted_reg) begin
                        zcur_reg  <= '0;
                        state_reg <= S_SCAN;
                    end else begin
                        zcur_reg   <= zpos_reg;
                        zw_key_reg <= z_reg;
                        zw_cnt_reg <= '0;
                        phase_reg  <= PH_MAIN;
                        state_reg  <= S_ZW;
                    end
                end

                // directory probe, one bucket per cycle
                S_ZW: begin
                    if (!cur_valid) begin
                        zw_res_reg <= ZW_FREE;
                        state_reg  <= S_ZDONE;
                    end else if (cur_key == zw_key_reg) begin
                        zw_res_reg <= ZW_HIT;
                        state_reg  <= S_ZDONE;
                    end else if (zw_cnt_reg == ZLAST) begin
                        zw_res_reg <= ZW_FULL;
                        state_reg  <= S_ZDONE;
                    end else begin
                        zcur_reg   <= zcur_reg + 1'b1;
                        zw_cnt_reg <= zw_cnt_reg + 1'b1;
                    end
                end

                S_ZDONE: begin
                    // list walks the row from the top; publish only on the main walk of update or migrate
                    epos_reg   <= (mode_reg == MODE_LIST) ? '0 : npos_reg;
                    ew_cnt_reg <= '0;
                    ew_pub_reg <= ((mode_reg == MODE_UPDATE) || (mode_reg == MODE_MIGRATE))
                               && (phase_reg != PH_PREV) && (zw_res_reg != ZW_FULL);
                    case (mode_reg)
                        MODE_LOOKUP: begin
                            if (zw_res_reg == ZW_HIT) begin
                                state_reg <= S_EWRD;
                            end else begin
                                zcur_reg  <= '0;
                                state_reg <= S_SCAN;
                            end
                        end
                        MODE_UPDATE, MODE_MIGRATE: begin
                            if (phase_reg == PH_PREV) begin
                                state_reg <= (zw_res_reg == ZW_HIT) ? S_EWRD : S_FINRES;
                            end else if (zw_res_reg == ZW_FULL) begin
                                res_status_reg <= ST_ZONE_FULL;
                                state_reg      <= S_MIGCHK;
                            end else begin
                                if (zw_res_reg == ZW_FREE) begin
                                    zone_valid_reg[zcur_reg] <= 1'b1;
                                    zone_key_reg[zcur_reg]   <= z_reg;
                                    zone_seal_reg[zcur_reg]  <= 1'b0;
                                    res_seal_reg             <= 1'b0;
                                end else begin
                                    res_seal_reg <= cur_seal;
                                end
                                state_reg <= S_EWRD;
                            end
                        end
                        MODE_REMOVE: begin
                            if (zw_res_reg == ZW_HIT) begin
                                state_reg <= S_EWRD;
                            end else begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_FIN;
                            end
                        end
                        MODE_SEAL_SET: begin
                            if (zw_res_reg == ZW_FULL) begin
                                res_status_reg <= ST_ZONE_FULL;
                            end else begin
                                if (zw_res_reg == ZW_FREE) begin
                                    zone_valid_reg[zcur_reg] <= 1'b1;
                                    zone_key_reg[zcur_reg]   <= z_reg;
                                end
                                zone_seal_reg[zcur_reg] <= sv_reg;
                                res_zone_reg            <= z_reg;
                                res_seal_reg            <= sv_reg;
                            end
                            state_reg <= S_FIN;
                        end
                        MODE_SEAL_GET: begin
                            if (zw_res_reg == ZW_HIT) begin
                                res_zone_reg <= z_reg;
                                res_seal_reg <= cur_seal;
                            end else begin
                                res_status_reg <= ST_NOT_FOUND;
                            end
                            state_reg <= S_FIN;
                        end
                        default: begin
                            // list
                            if (zw_res_reg == ZW_HIT) begin
                                pend_v_reg <= 1'b0;
                                state_reg  <= S_LRD;
                            end else begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_FIN;
                            end
                        end
                    endcase
                end

                S_EWRD: state_reg <= S_EWCK;

                // entry probe; RAM write for claim or tombstone is issued here
                S_EWCK: begin
                    if (ew_pub_reg ? ew_claim : ew_match) begin
                        ew_hit_reg  <= 1'b1;
                        ew_slot_reg <= rdata_reg.slot;
                        state_reg   <= S_EDONE;
                    end else if ((!ew_pub_reg && rdata_reg.tag == TAG_EMPTY)
                                 || ew_cnt_reg == ELAST) begin
                        ew_hit_reg <= 1'b0;
                        state_reg  <= S_EDONE;
                    end else begin
                        epos_reg   <= epos_reg + 1'b1;
                        ew_cnt_reg <= ew_cnt_reg + 1'b1;
                        state_reg  <= S_EWRD;
                    end
                end

                S_EDONE: begin
                    case (mode_reg)
                        MODE_LOOKUP: begin
                            if (ew_hit_reg) begin
                                res_zone_reg <= (phase_reg == PH_SCAN) ? cur_key : z_reg;
                                res_node_reg <= n_reg;
                                res_slot_reg <= ew_slot_reg;
                                res_seal_reg <= cur_seal;
                                state_reg    <= S_FIN;
                            end else if (phase_reg != PH_SCAN) begin
                                zcur_reg  <= '0;
                                state_reg <= S_SCAN;
                            end else if (zcur_reg == ZLAST) begin
                                res_status_reg <= ST_NOT_FOUND;
                                state_reg      <= S_FIN;
                            end else begin
                                zcur_reg  <= zcur_reg + 1'b1;
                                state_reg <= S_SCAN;
                            end
                        end
                        MODE_UPDATE, MODE_MIGRATE: begin
                            if (phase_reg == PH_PREV) begin
                                state_reg <= S_FINRES;
                            end else begin
                                res_status_reg <= ew_hit_reg ? ST_OK : ST_NODE_FULL;
                                state_reg      <= S_MIGCHK;
                            end
                        end
                        default: begin
                            // remove
                            if (ew_hit_reg) begin
                                res_zone_reg <= z_reg;
                                res_node_reg <= n_reg;
                                res_slot_reg <= ew_slot_reg;
                                res_seal_reg <= cur_seal;
                            end else begin
                                res_status_reg <= ST_NOT_FOUND;
                            end
                            state_reg <= S_FIN;
                        end
                    endcase
                end

                // fallback lookup over the directory, skipping the hint zone
                S_SCAN: begin
                    if (cur_valid && !(hinted_reg && cur_key == z_reg)) begin
                        epos_reg   <= npos_reg;
                        ew_cnt_reg <= '0;
                        ew_pub_reg <= 1'b0;
                        phase_reg  <= PH_SCAN;
                        state_reg  <= S_EWRD;
                    end else if (zcur_reg == ZLAST) begin
                        res_status_reg <= ST_NOT_FOUND;
                        state_reg      <= S_FIN;
                    end else begin
                        zcur_reg <= zcur_reg + 1'b1;
                    end
                end

                S_MIGCHK: begin
                    if (mode_reg == MODE_MIGRATE && pz_reg != inv_zone_reg
                        && pz_reg != z_reg) begin
                        zcur_reg   <= ppos_reg;
                        zw_key_reg <= pz_reg;
                        zw_cnt_reg <= '0;
                        phase_reg  <= PH_PREV;
                        state_reg  <= S_ZW;
                    end else begin
                        state_reg <= S_FINRES;
                    end
                end

                S_FINRES: begin
                    if (res_status_reg == ST_OK) begin
                        res_zone_reg <= z_reg;
                        res_node_reg <= n_reg;
                        res_slot_reg <= s_reg;
                    end else begin
                        res_seal_reg <= 1'b0;
                    end
                    state_reg <= S_FIN;
                end

                S_LRD: state_reg <= S_LCK;

                S_LCK: begin
                    if (rdata_reg.tag == TAG_LIVE) begin
                        if (!pend_v_reg || out_free) begin
                            if (pend_v_reg) begin
                                m_status_reg <= ST_OK;
                                m_zone_reg   <= z_reg;
                                m_node_reg   <= pend_node_reg;
                                m_slot_reg   <= pend_slot_reg;
                                m_seal_reg   <= cur_seal;
                                m_last_reg   <= 1'b0;
                            end
                            pend_v_reg    <= 1'b1;
                            pend_node_reg <= rdata_reg.node;
                            pend_slot_reg <= rdata_reg.slot;
                            epos_reg      <= epos_reg + 1'b1;
                            state_reg     <= (epos_reg == ELAST) ? S_LEND : S_LRD;
                        end
                    end else begin
                        epos_reg  <= epos_reg + 1'b1;
                        state_reg <= (epos_reg == ELAST) ? S_LEND : S_LRD;
                    end
                end

                S_LEND: begin
                    if (!pend_v_reg) begin
                        res_status_reg <= ST_NOT_FOUND;
                        res_zone_reg   <= z_reg;
                        res_seal_reg   <= cur_seal;
                        state_reg      <= S_FIN;
                    end else if (out_free) begin
                        m_status_reg <= ST_OK;
                        m_zone_reg   <= z_reg;
                        m_node_reg   <= pend_node_reg;
                        m_slot_reg   <= pend_slot_reg;
                        m_seal_reg   <= cur_seal;
                        m_last_reg   <= 1'b1;
                        pend_v_reg   <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end

                // S_FIN: hand the single result to the output register
                default: begin
                    if (out_free) begin
                        m_status_reg <= res_status_reg;
                        m_zone_reg   <= res_zone_reg;
                        m_node_reg   <= res_node_reg;
                        m_slot_reg   <= res_slot_reg;
                        m_seal_reg   <= res_seal_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== design/znlt_mix.sv =====
// ============================================================================
// znlt_mix: iterative splitmix64 finalizer variant with a final shift of 33
// One 32x32 multiplier; each 64-bit product takes three partial products.
// ============================================================================
module znlt_mix (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] x_in,
    output logic        done,
    output logic [63:0] h
);
    import znlt_pkg::*;

    logic        busy_reg;
    logic [2:0]  stp_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] cst;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    // low 64 bits of x*c = lo*lo + ((lo*hi + hi*lo) << 32)
    always_comb begin
        cst   = stp_reg[2] ? MIX_C2 : MIX_C1;
        mul_a = (stp_reg[1:0] == 2'd2) ? x_reg[63:32] : x_reg[31:0];
        mul_b = (stp_reg[1:0] == 2'd1) ? cst[63:32] : cst[31:0];
        prod  = 64'(mul_a) * 64'(mul_b);
    end

    assign done = busy_reg && (stp_reg == 3'd7);
    assign h    = acc_reg ^ (acc_reg >> 33);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            stp_reg  <= 3'd0;
        end else if (start) begin
            x_reg    <= x_in ^ (x_in >> 30);
            stp_reg  <= 3'd0;
            busy_reg <= 1'b1;
        end else if (busy_reg) begin
            case (stp_reg[1:0])
                2'd0: acc_reg <= prod;
                2'd1, 2'd2: acc_reg[63:32] <= acc_reg[63:32] + prod[31:0];
                default: begin
                    if (stp_reg[2]) busy_reg <= 1'b0;
                    else            x_reg <= acc_reg ^ (acc_reg >> 27);
                end
            endcase
            stp_reg <= stp_reg + 3'd1;
        end
    end

endmodule

// ===== design/znlt_checker.sv =====
// ============================================================================
// znlt_props: port-level assertions of the location table
// Attached to the top level by bind.
// ============================================================================
module znlt_props (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [2:0]                     m_status,
    input logic                           m_last
);
    import znlt_pkg::*;

    // result held until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // clearing pass blocks requests right after reset
    a_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("request taken during clearing pass");

    // one request in work at a time
    a_serial: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while busy");

    // only list results may be non-final, and they are all hits
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_status == ST_OK)
        else $error("non-final result with error status");

    a_inval: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_INVALID |-> m_last)
        else $error("invalid-id result not final");

endmodule

bind zoned_node_location_table_unit znlt_props u_znlt_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_last   (m_last)
);

// ===== test/znlt_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// znlt_checker: result checker for the zoned node location table
// Watches the request, result and config channels, keeps a shadow copy of
// the zone directory and node tables, and checks every result in order.
// ============================================================================
module znlt_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_mode,
    input  logic [31:0] s_zone_id,
    input  logic [31:0] s_node_id,
    input  logic [31:0] s_slot_id,
    input  logic [31:0] s_prev_zone_id,
    input  logic        s_seal_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [31:0] m_found_zone,
    input  logic [31:0] m_found_node,
    input  logic [31:0] m_found_slot,
    input  logic        m_sealed,
    input  logic        m_last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [znlt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending
);
    import znlt_pkg::*;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] zone;
        logic [31:0] node;
        logic [31:0] slot;
        logic        sealed;
        logic        last;
    } loc_result_t;

    loc_result_t due_results[$];

    logic [31:0] no_zone;
    logic [31:0] no_node;
    logic        dir_valid [ZONE_SLOTS];
    logic [31:0] dir_key   [ZONE_SLOTS];
    logic        dir_seal  [ZONE_SLOTS];
    logic [1:0]  ent_tag   [DEPTH];
    logic [31:0] ent_node  [DEPTH];
    logic [31:0] ent_slot  [DEPTH];

    function automatic logic [63:0] splitmix(logic [63:0] x);
        x = x ^ (x >> 30);
        x = x * MIX_C1;
        x = x ^ (x >> 27);
        x = x * MIX_C2;
        x = x ^ (x >> 33);
        return x;
    endfunction

    function automatic int zone_home(logic [31:0] z);
        logic [63:0] h;
        h = splitmix({32'd0, z ^ ZONE_SALT});
        return int'(h[ZIDX_W-1:0]);
    endfunction

    function automatic int zone_locate(logic [31:0] z);
        int p;
        p = zone_home(z);
        for (int i = 0; i < ZONE_SLOTS; i++) begin
            if (!dir_valid[p]) return -1;
            if (dir_key[p] == z) return p;
            p = (p + 1) % ZONE_SLOTS;
        end
        return -1;
    endfunction

    function automatic int zone_claim(logic [31:0] z);
        int p;
        p = zone_locate(z);
        if (p >= 0) return p;
        p = zone_home(z);
        for (int i = 0; i < ZONE_SLOTS; i++) begin
            if (!dir_valid[p]) begin
                dir_valid[p] = 1'b1;
                dir_key[p]   = z;
                dir_seal[p]  = 1'b0;
                return p;
            end
            p = (p + 1) % ZONE_SLOTS;
        end
        return -1;
    endfunction

    function automatic int node_home(logic [31:0] n);
        logic [63:0] h;
        h = splitmix({32'd0, n});
        return int'(h[EIDX_W-1:0]);
    endfunction

    // address of the live entry of node n in zone zi, or -1
    function automatic int entry_locate(int zi, logic [31:0] n);
        int p;
        int a;
        p = node_home(n);
        for (int i = 0; i < TRACKER_SLOTS; i++) begin
            a = zi * TRACKER_SLOTS + p;
            if (ent_tag[a] == TAG_EMPTY) return -1;
            if (ent_tag[a] == TAG_LIVE && ent_node[a] == n) return a;
            p = (p + 1) % TRACKER_SLOTS;
        end
        return -1;
    endfunction

    function automatic int entry_store(int zi, logic [31:0] n, logic [31:0] s);
        int p;
        int a;
        p = node_home(n);
        for (int i = 0; i < TRACKER_SLOTS; i++) begin
            a = zi * TRACKER_SLOTS + p;
            if (ent_tag[a] != TAG_LIVE || ent_node[a] == n) begin
                ent_tag[a]  = TAG_LIVE;
                ent_node[a] = n;
                ent_slot[a] = s;
                return a;
            end
            p = (p + 1) % TRACKER_SLOTS;
        end
        return -1;
    endfunction

    function automatic void push_result(logic [2:0] st, logic [31:0] z, logic [31:0] n,
                                        logic [31:0] s, logic seal, logic last);
        loc_result_t r;
        r.status = st;
        r.zone   = z;
        r.node   = n;
        r.slot   = s;
        r.sealed = seal;
        r.last   = last;
        due_results.push_back(r);
    endfunction

    function automatic void predict_request(logic [2:0] mode, logic [31:0] z,
                                            logic [31:0] n, logic [31:0] s,
                                            logic [31:0] pz, logic sv);
        logic zbad;
        logic nbad;
        logic seal;
        logic [2:0] st;
        int zi;
        int a;
        int hits;
        zbad = (z == no_zone);
        nbad = (n == no_node);
        case (mode)
            MODE_LOOKUP: begin
                if (nbad) begin
                    push_result(ST_INVALID, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                if (!zbad) begin
                    zi = zone_locate(z);
                    if (zi >= 0) begin
                        a = entry_locate(zi, n);
                        if (a >= 0) begin
                            push_result(ST_OK, z, n, ent_slot[a], dir_seal[zi], 1'b1);
                            return;
                        end
                    end
                end
                for (int i = 0; i < ZONE_SLOTS; i++) begin
                    if (!dir_valid[i]) continue;
                    if (!zbad && dir_key[i] == z) continue;
                    a = entry_locate(i, n);
                    if (a >= 0) begin
                        push_result(ST_OK, dir_key[i], n, ent_slot[a], dir_seal[i], 1'b1);
                        return;
                    end
                end
                push_result(ST_NOT_FOUND, 0, 0, 0, 1'b0, 1'b1);
            end
            MODE_UPDATE, MODE_MIGRATE: begin
                if (nbad || zbad) begin
                    push_result(ST_INVALID, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                seal = 1'b0;
                zi = zone_claim(z);
                if (zi < 0) st = ST_ZONE_FULL;
                else begin
                    seal = dir_seal[zi];
                    st = (entry_store(zi, n, s) < 0) ? ST_NODE_FULL : ST_OK;
                end
                // migrate retires the old entry whatever the update did
                if (mode == MODE_MIGRATE && pz != no_zone && pz != z) begin
                    zi = zone_locate(pz);
                    if (zi >= 0) begin
                        a = entry_locate(zi, n);
                        if (a >= 0) ent_tag[a] = TAG_TOMB;
                    end
                end
                if (st == ST_OK) push_result(ST_OK, z, n, s, seal, 1'b1);
                else push_result(st, 0, 0, 0, 1'b0, 1'b1);
            end
            MODE_REMOVE: begin
                if (nbad || zbad) begin
                    push_result(ST_INVALID, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                zi = zone_locate(z);
                a = (zi >= 0) ? entry_locate(zi, n) : -1;
                if (a < 0) begin
                    push_result(ST_NOT_FOUND, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                ent_tag[a] = TAG_TOMB;
                push_result(ST_OK, z, n, ent_slot[a], dir_seal[zi], 1'b1);
            end
            MODE_SEAL_SET: begin
                if (zbad) begin
                    push_result(ST_INVALID, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                zi = zone_claim(z);
                if (zi < 0) begin
                    push_result(ST_ZONE_FULL, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                dir_seal[zi] = sv;
                push_result(ST_OK, z, 0, 0, sv, 1'b1);
            end
            MODE_SEAL_GET: begin
                if (zbad) begin
                    push_result(ST_INVALID, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                zi = zone_locate(z);
                if (zi < 0) push_result(ST_NOT_FOUND, 0, 0, 0, 1'b0, 1'b1);
                else push_result(ST_OK, z, 0, 0, dir_seal[zi], 1'b1);
            end
            MODE_LIST: begin
                if (zbad) begin
                    push_result(ST_INVALID, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                zi = zone_locate(z);
                if (zi < 0) begin
                    push_result(ST_NOT_FOUND, 0, 0, 0, 1'b0, 1'b1);
                    return;
                end
                hits = 0;
                for (int i = 0; i < TRACKER_SLOTS; i++) begin
                    a = zi * TRACKER_SLOTS + i;
                    if (ent_tag[a] != TAG_LIVE) continue;
                    push_result(ST_OK, z, ent_node[a], ent_slot[a], dir_seal[zi], 1'b0);
                    hits++;
                end
                if (hits == 0) push_result(ST_NOT_FOUND, z, 0, 0, dir_seal[zi], 1'b1);
                else due_results[$].last = 1'b1;
            end
            default: push_result(ST_INVALID, 0, 0, 0, 1'b0, 1'b1);
        endcase
    endfunction

    always @(posedge aclk) begin
        loc_result_t want;
        if (!aresetn) begin
            no_zone = 32'hFFFF_FFFF;
            no_node = 32'h0;
            for (int i = 0; i < ZONE_SLOTS; i++) begin
                dir_valid[i] = 1'b0;
                dir_seal[i]  = 1'b0;
            end
            for (int i = 0; i < DEPTH; i++) ent_tag[i] = TAG_EMPTY;
            due_results.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_INV_ZONE: no_zone = cfg_data;
                    CFG_INV_NODE: no_node = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predict_request(s_mode, s_zone_id, s_node_id, s_slot_id,
                                s_prev_zone_id, s_seal_value);
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    if (errors < 10)
                        $display("[%0t] unexpected result: st=%0d zone=%h node=%h",
                                 $realtime, m_status, m_found_zone, m_found_node);
                    errors++;
                end else begin
                    want = due_results.pop_front();
                    if (m_status !== want.status || m_found_zone !== want.zone ||
                        m_found_node !== want.node || m_found_slot !== want.slot ||
                        m_sealed !== want.sealed || m_last !== want.last) begin
                        if (errors < 10) begin
                            $display({"[%0t] mismatch exp: st=%0d zone=%h node=%h",
                                      " slot=%h seal=%b last=%b"},
                                     $realtime, want.status, want.zone, want.node,
                                     want.slot, want.sealed, want.last);
                            $display({"[%0t]          got: st=%0d zone=%h node=%h",
                                      " slot=%h seal=%b last=%b"},
                                     $realtime, m_status, m_found_zone, m_found_node,
                                     m_found_slot, m_sealed, m_last);
                        end
                        errors++;
                    end
                end
            end
        end
        pending = due_results.size();
    end

endmodule

// ===== test/zoned_node_location_table_unit_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// zoned_node_location_table_unit_tb: top of the location table testbench
// Directed requests for each mode and corner, a table-fill pass, then random
// requests over a small pool of zones and nodes under three invalid-id
// settings, with random stalls on both channels. Checking lives in znlt_checker.
// ============================================================================
module zoned_node_location_table_unit_tb;
    import znlt_pkg::*;

    localparam logic [2:0] MODE_UNDEF  = 3'd7;  // no such mode, must be rejected
    localparam int         QUIET_LIMIT = 50000; // cycles without any handshake
    localparam int         DRAIN_WAIT  = 120;   // covers the longest request tail

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode = MODE_LOOKUP;
    logic [31:0] s_zone_id = '0;
    logic [31:0] s_node_id = '0;
    logic [31:0] s_slot_id = '0;
    logic [31:0] s_prev_zone_id = '0;
    logic        s_seal_value = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_found_zone;
    logic [31:0] m_found_node;
    logic [31:0] m_found_slot;
    logic        m_sealed;
    logic        m_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_INV_ZONE;
    logic [31:0] cfg_data = '0;

    int errors;
    int pending;
    int quiet;
    bit calm = 1'b0;            // when set neither side stalls

    // invalid codes currently programmed, so stimulus can aim at them
    logic [31:0] cur_no_zone = 32'hFFFF_FFFF;
    logic [31:0] cur_no_node = 32'h0;
    logic [31:0] zone_pool [6];
    logic [31:0] node_pool [24];

    zoned_node_location_table_unit dut (.*);

    znlt_checker u_checker (.*);

    always #4 aclk = ~aclk;

    // result side: random stalls, ready low about a fifth of the time, unless calm
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // watchdog: any handshake restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // One request; valid stays high into the next request unless a gap is taken.
    task automatic send(logic [2:0] mode, logic [31:0] z, logic [31:0] n,
                        logic [31:0] s, logic [31:0] pz, logic sv);
        if (!calm && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_mode         <= mode;
        s_zone_id      <= z;
        s_node_id      <= n;
        s_slot_id      <= s;
        s_prev_zone_id <= pz;
        s_seal_value   <= sv;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off until every request has been answered, plus the tail latency
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // writes both registers back to back; only called while idle
    task automatic program_codes(logic [31:0] zc, logic [31:0] nc);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_INV_ZONE;
        cfg_data  <= zc;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_INV_NODE;
        cfg_data  <= nc;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cur_no_zone = zc;
        cur_no_node = nc;
    endtask

    // Random request: mostly well-formed over the pools so entries collide,
    // move and get retired; some invalid ids, fresh keys and bad modes.
    task automatic random_request();
        int          pick;
        logic [2:0]  mode;
        logic [31:0] z;
        logic [31:0] n;
        logic [31:0] pz;
        pick = $urandom_range(99);
        if      (pick < 30) mode = MODE_UPDATE;
        else if (pick < 50) mode = MODE_LOOKUP;
        else if (pick < 62) mode = MODE_MIGRATE;
        else if (pick < 74) mode = MODE_REMOVE;
        else if (pick < 80) mode = MODE_SEAL_SET;
        else if (pick < 86) mode = MODE_SEAL_GET;
        else if (pick < 97) mode = MODE_LIST;
        else                mode = MODE_UNDEF;
        pick = $urandom_range(99);
        z = zone_pool[$urandom_range(5)];
        if (pick < 5) z = cur_no_zone;
        // fresh zones only where nothing gets attached, the directory is small
        else if (pick < 15 && mode != MODE_UPDATE && mode != MODE_MIGRATE &&
                 mode != MODE_SEAL_SET) z = $urandom;
        pick = $urandom_range(99);
        if      (pick < 80) n = node_pool[$urandom_range(23)];
        else if (pick < 90) n = cur_no_node;
        else                n = $urandom;
        pick = $urandom_range(99);
        if      (pick < 70) pz = zone_pool[$urandom_range(5)];
        else if (pick < 80) pz = z;
        else if (pick < 90) pz = cur_no_zone;
        else                pz = $urandom;
        send(mode, z, n, $urandom, pz, 1'($urandom_range(1)));
    endtask

    localparam logic [31:0] ZA = 32'h0000_0011;
    localparam logic [31:0] ZB = 32'h8000_0022;
    localparam logic [31:0] ZC = 32'h0000_0033;
    localparam logic [31:0] ZF = 32'h7FFF_FFF4;   // zone filled to the brim

    initial begin
        for (int i = 0; i < 6; i++) zone_pool[i] = $urandom;
        for (int i = 0; i < 24; i++) node_pool[i] = i + 1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // reset values, written while the tag clearing pass still runs
        program_codes(32'hFFFF_FFFF, 32'h0);

        // --- directed: every mode and its corners ---
        send(MODE_LOOKUP,   ZA, 32'h0, 0, 0, 1'b0);          // invalid node
        send(MODE_LOOKUP,   ZA, 32'h5, 0, 0, 1'b0);          // nothing attached yet
        send(MODE_UPDATE,   ZA, 32'h5, 32'h0000_AAAA, 0, 1'b0);
        send(MODE_UPDATE,   ZA, 32'h5, 32'hFFFF_FFFF, 0, 1'b0); // overwrite live match
        send(MODE_LOOKUP,   32'hFFFF_FFFF, 32'h5, 0, 0, 1'b0); // no hint, scan
        send(MODE_LOOKUP,   ZB, 32'h5, 0, 0, 1'b0);          // unknown hint
        send(MODE_MIGRATE,  ZB, 32'h5, 32'h1234_5678, ZA, 1'b0);
        send(MODE_LOOKUP,   ZA, 32'h5, 0, 0, 1'b0);          // hint misses, found in ZB
        send(MODE_REMOVE,   ZA, 32'h5, 0, 0, 1'b0);          // tombstoned by migrate
        send(MODE_REMOVE,   ZB, 32'h5, 0, 0, 1'b0);
        send(MODE_SEAL_SET, ZB, 0, 0, 0, 1'b1);
        send(MODE_SEAL_GET, ZB, 0, 0, 0, 1'b0);
        send(MODE_SEAL_GET, ZC, 0, 0, 0, 1'b0);              // unknown zone
        send(MODE_SEAL_SET, 32'hFFFF_FFFF, 0, 0, 0, 1'b1);   // invalid zone
        send(MODE_LIST,     ZB, 0, 0, 0, 1'b0);              // only tombstones
        send(MODE_LIST,     ZC, 0, 0, 0, 1'b0);              // unknown zone
        send(MODE_UPDATE,   ZA, 32'hFFFF_FFFF, 32'h0, 0, 1'b0);
        send(MODE_LIST,     ZA, 0, 0, 0, 1'b0);
        send(MODE_UNDEF,    ZA, 32'h5, 0, 0, 1'b0);
        send(MODE_MIGRATE,  ZA, 32'hFFFF_FFFF, 32'h77, ZA, 1'b0); // prev equals zone
        send(MODE_UPDATE,   32'hFFFF_FFFF, 32'h9, 0, 0, 1'b0);
        send(MODE_REMOVE,   ZC, 32'h9, 0, 0, 1'b0);              // unknown zone

        // --- fill one node table: the 65th update finds no room ---
        for (int i = 0; i < 65; i++) send(MODE_UPDATE, ZF, 32'h1000 + i, $urandom, 0, 1'b0);
        send(MODE_LIST,   ZF, 0, 0, 0, 1'b0);                // 64 results in a row
        send(MODE_LOOKUP, ZF, 32'h9999, 0, 0, 1'b0);         // full-row miss
        send(MODE_REMOVE, ZF, 32'h1007, 0, 0, 1'b0);
        send(MODE_UPDATE, ZF, 32'h2000, 32'h55, 0, 1'b0);    // reuses the tombstone

        // --- random, first setting; one calm stretch and one full pause ---
        for (int i = 0; i < 40; i++) begin
            calm = (i >= 10 && i < 30);
            if (i == 32) drain();
            random_request();
        end
        calm = 1'b0;

        // --- random, opposite extremes of both codes ---
        drain();
        program_codes(32'h0, 32'hFFFF_FFFF);
        for (int i = 0; i < 25; i++) random_request();

        // --- random, codes that collide with live zone and node keys ---
        drain();
        program_codes(zone_pool[0], node_pool[3]);
        for (int i = 0; i < 25; i++) random_request();

        // --- attach fresh zones until the directory is full ---
        for (int i = 0; i < 18; i++)
            send(MODE_SEAL_SET, $urandom, 0, 0, 0, 1'($urandom_range(1)));
        send(MODE_UPDATE,  32'h0BAD_0001, 32'h1, 32'h2, 0, 1'b0);
        send(MODE_MIGRATE, 32'h0BAD_0002, node_pool[1], 32'h3, zone_pool[1], 1'b0);
        send(MODE_LOOKUP,  32'h0BAD_0002, node_pool[1], 0, 0, 1'b0);
        for (int i = 0; i < 15; i++) random_request();

        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/znlt_pkg.sv
design/znlt_mix.sv
design/zoned_node_location_table_unit.sv
design/znlt_checker.sv
test/znlt_checker.sv
test/zoned_node_location_table_unit_tb.sv
